// ===== design/memory_map_bus_decoder_core_assert.svh =====
// Assertion macros shared by the memory map bus decoder RTL.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef MEMORY_MAP_BUS_DECODER_CORE_ASSERT_SVH
`define MEMORY_MAP_BUS_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MMBD_ASSERT_IMPL(lbl, clk_sig, rst_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MMBD_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mmbd_pkg.sv =====
// Package for the memory map bus decoder: target codes, map constants,
// controller types and the address decode function. Depends on nothing.
`default_nettype none

package mmbd_pkg;

    localparam int WORK_RAM_BYTES = 8192;
    localparam int HIGH_RAM_BYTES = 127;

    localparam logic [15:0] DMA_LIMIT   = 16'hFF00;
    localparam logic [15:0] ECHO_START  = 16'hE000;
    localparam logic [15:0] ECHO_OFFSET = 16'h2000;
    localparam logic [7:0]  OPEN_BUS    = 8'hFF;

    typedef enum logic [3:0] {
        TGT_BLOCKED  = 4'd0,
        TGT_BOOT     = 4'd1,
        TGT_ROM0     = 4'd2,
        TGT_ROMX     = 4'd3,
        TGT_VRAM     = 4'd4,
        TGT_CRAM     = 4'd5,
        TGT_WRAM     = 4'd6,
        TGT_OAM      = 4'd7,
        TGT_UNUSABLE = 4'd8,
        TGT_HRAM     = 4'd9,
        TGT_LOCK     = 4'd10,
        TGT_IRQ      = 4'd11,
        TGT_DMA      = 4'd12,
        TGT_TIMER    = 4'd13,
        TGT_PPU      = 4'd14,
        TGT_NONE     = 4'd15
    } target_t;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } access_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_ACCESS = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // capture the word, decode it and do the RAM access
        logic load_out;  // move the finished result into the output register
    } ctrl_cmd_t;

    // Decode of an address that is not blocked by DMA.
    function automatic target_t decode(input logic [15:0] addr, input logic locked);
        target_t tgt;
        begin
            tgt = TGT_NONE;
            if (addr <= 16'h00FF && !locked)
            begin
                tgt = TGT_BOOT;
            end
            else if (addr <= 16'h3FFF)
            begin
                tgt = TGT_ROM0;
            end
            else if (addr <= 16'h7FFF)
            begin
                tgt = TGT_ROMX;
            end
            else if (addr <= 16'h9FFF)
            begin
                tgt = TGT_VRAM;
            end
            else if (addr <= 16'hBFFF)
            begin
                tgt = TGT_CRAM;
            end
            else if (addr <= 16'hFDFF)
            begin
                tgt = TGT_WRAM;
            end
            else if (addr <= 16'hFE9F)
            begin
                tgt = TGT_OAM;
            end
            else if (addr <= 16'hFEFF)
            begin
                tgt = TGT_UNUSABLE;
            end
            else if (addr inside {[16'hFF80:16'hFFFE]})
            begin
                tgt = TGT_HRAM;
            end
            else if (addr == 16'hFF50)
            begin
                tgt = TGT_LOCK;
            end
            else if (addr == 16'hFF0F || addr == 16'hFFFF)
            begin
                tgt = TGT_IRQ;
            end
            else if (addr == 16'hFF46)
            begin
                tgt = TGT_DMA;
            end
            else if (addr inside {[16'hFF04:16'hFF07]})
            begin
                tgt = TGT_TIMER;
            end
            else if (addr inside {[16'hFF40:16'hFF4B]})
            begin
                tgt = TGT_PPU;
            end
            return tgt;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/mmbd_datapath.sv =====
// Datapath of the memory map bus decoder: input capture, decode, boot lock,
// work RAM, high RAM and the output register. Depends on mmbd_pkg.
`default_nettype none

module mmbd_datapath #(
    parameter int WORK_RAM_BYTES = mmbd_pkg::WORK_RAM_BYTES,
    parameter int HIGH_RAM_BYTES = mmbd_pkg::HIGH_RAM_BYTES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mmbd_pkg::ctrl_cmd_t cmd,
    input  wire logic                command,
    input  wire logic [15:0]         bus_address,
    input  wire logic [7:0]          write_byte,
    input  wire logic                dma_busy,
    input  wire logic [7:0]          dma_byte,
    output logic [3:0]               target,
    output logic [15:0]              target_address,
    output logic                     forward_write,
    output logic                     local_answer,
    output logic [7:0]               read_data
);

    localparam int WA = $clog2(WORK_RAM_BYTES);
    localparam int HA = $clog2(HIGH_RAM_BYTES);

    logic [7:0] wram_mem [WORK_RAM_BYTES];
    logic [7:0] hram_mem [HIGH_RAM_BYTES];

    logic              lock_reg, lock_next;
    mmbd_pkg::target_t tgt_in;
    logic [WA-1:0]     wram_idx;
    logic [HA-1:0]     hram_idx;
    logic              is_write;

    // Captured access.
    mmbd_pkg::target_t tgt_reg;
    logic              wr_reg;
    logic [15:0]       addr_reg;
    logic [7:0]        dbyte_reg;
    logic [7:0]        wram_q_reg;
    logic [7:0]        hram_q_reg;

    // Result of the captured access.
    logic [15:0] taddr_c;
    logic        fwd_c;
    logic        local_c;
    logic [7:0]  rdata_c;

    logic [3:0]  target_reg;
    logic [15:0] target_address_reg;
    logic        forward_write_reg;
    logic        local_answer_reg;
    logic [7:0]  read_data_reg;

    assign is_write = (command == mmbd_pkg::CMD_WRITE);

    always_comb
    begin
        if (dma_busy && bus_address < mmbd_pkg::DMA_LIMIT)
        begin
            tgt_in = mmbd_pkg::TGT_BLOCKED;
        end
        else
        begin
            tgt_in = mmbd_pkg::decode(bus_address, lock_reg);
        end
    end

    // Echo addresses share the low 13 bits with their work RAM alias, and high
    // RAM starts on a 128-byte boundary, so both indexes are plain bit fields.
    assign wram_idx = bus_address[WA-1:0];
    assign hram_idx = bus_address[HA-1:0];

    assign lock_next = lock_reg
        | (cmd.load_in & is_write & (tgt_in == mmbd_pkg::TGT_LOCK));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg <= 1'b0;
        end
        else
        begin
            lock_reg <= lock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            if (is_write && tgt_in == mmbd_pkg::TGT_WRAM)
            begin
                wram_mem[wram_idx] <= write_byte;
            end
            wram_q_reg <= wram_mem[wram_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            if (is_write && tgt_in == mmbd_pkg::TGT_HRAM)
            begin
                hram_mem[hram_idx] <= write_byte;
            end
            hram_q_reg <= hram_mem[hram_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            tgt_reg   <= tgt_in;
            wr_reg    <= is_write;
            addr_reg  <= bus_address;
            dbyte_reg <= dma_byte;
        end
    end

    always_comb
    begin
        taddr_c = addr_reg;
        fwd_c   = 1'b0;
        local_c = 1'b0;
        rdata_c = 8'd0;
        if (tgt_reg == mmbd_pkg::TGT_WRAM && addr_reg >= mmbd_pkg::ECHO_START)
        begin
            taddr_c = addr_reg - mmbd_pkg::ECHO_OFFSET;
        end
        case (tgt_reg)
            mmbd_pkg::TGT_BLOCKED:
            begin
                local_c = !wr_reg;
                rdata_c = wr_reg ? 8'd0 : dbyte_reg;
            end
            mmbd_pkg::TGT_WRAM:
            begin
                local_c = !wr_reg;
                rdata_c = wr_reg ? 8'd0 : wram_q_reg;
            end
            mmbd_pkg::TGT_HRAM:
            begin
                local_c = !wr_reg;
                rdata_c = wr_reg ? 8'd0 : hram_q_reg;
            end
            mmbd_pkg::TGT_LOCK, mmbd_pkg::TGT_UNUSABLE, mmbd_pkg::TGT_NONE:
            begin
                local_c = !wr_reg;
                rdata_c = wr_reg ? 8'd0 : mmbd_pkg::OPEN_BUS;
            end
            default:
            begin
                fwd_c = wr_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            target_reg         <= tgt_reg;
            target_address_reg <= taddr_c;
            forward_write_reg  <= fwd_c;
            local_answer_reg   <= local_c;
            read_data_reg      <= rdata_c;
        end
    end

    assign target         = target_reg;
    assign target_address = target_address_reg;
    assign forward_write  = forward_write_reg;
    assign local_answer   = local_answer_reg;
    assign read_data      = read_data_reg;

endmodule

`default_nettype wire

// ===== design/mmbd_ctrl.sv =====
// Controller of the memory map bus decoder: two-state sequencer and the
// output valid flag. Depends on mmbd_pkg.
`default_nettype none

module mmbd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output mmbd_pkg::ctrl_cmd_t       cmd
);

    mmbd_pkg::ctrl_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmbd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mmbd_pkg::ST_ACCESS;
                end
            end
            mmbd_pkg::ST_ACCESS:
            begin
                if (out_free)
                begin
                    state_next = mmbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            mmbd_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            mmbd_pkg::ST_ACCESS:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmbd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/memory_map_bus_decoder_core.sv =====
// Memory map bus decoder, top level. Flow: a word accepted in idle is captured
// and then moved into the output register once that register is free or draining.
// The controller takes no new word until that result is written, which it does
// in its access state, a state that a stalled output holds.
// Reset: asynchronous, active low; the boot ROM is mapped again and the
// sequencer idles. Work RAM and high RAM are not cleared.
`default_nettype none
`include "memory_map_bus_decoder_core_assert.svh"

module memory_map_bus_decoder_core #(
    parameter int WORK_RAM_BYTES = mmbd_pkg::WORK_RAM_BYTES,
    parameter int HIGH_RAM_BYTES = mmbd_pkg::HIGH_RAM_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input words: one CPU bus access each.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // From bit 0: bus_address[15:0], write_byte[23:16], dma_busy[24],
    // dma_byte[32:25], zero fill [39:33].
    input  wire logic [39:0] s_tdata,
    // Bit 0: command (0 read, 1 write).
    input  wire logic        s_tuser,
    // Output words: one decode result each.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // From bit 0: target[3:0], target_address[19:4], forward_write[20],
    // local_answer[21], read_data[29:22], zero fill [31:30].
    output logic [31:0]      m_tdata
);

    mmbd_pkg::ctrl_cmd_t cmd;

    logic [3:0]  target;
    logic [15:0] target_address;
    logic        forward_write;
    logic        local_answer;
    logic [7:0]  read_data;

    // The controller sequences each word: in idle it takes a word, which the
    // datapath decodes and uses for its RAM or lock access at that same edge;
    // in the access state the result is moved into the output register as
    // soon as that register is free or being drained.
    mmbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the boot lock, both RAMs with registered reads, the
    // captured access and the output register.
    mmbd_datapath #(
        .WORK_RAM_BYTES (WORK_RAM_BYTES),
        .HIGH_RAM_BYTES (HIGH_RAM_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .command        (s_tuser),
        .bus_address    (s_tdata[15:0]),
        .write_byte     (s_tdata[23:16]),
        .dma_busy       (s_tdata[24]),
        .dma_byte       (s_tdata[32:25]),
        .target         (target),
        .target_address (target_address),
        .forward_write  (forward_write),
        .local_answer   (local_answer),
        .read_data      (read_data)
    );

    assign m_tdata = {2'b00, read_data, local_answer, forward_write, target_address, target};

    // A word just taken must not be followed by another in the next cycle.
    `MMBD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "second word accepted while one is in flight")

    // A result is never both forwarded and answered here.
    `MMBD_ASSERT_IMPL(a_fwd_local_excl, clk, rst_n, m_tvalid,
        !(forward_write && local_answer), "forward and local answer together")

    // Nonzero read data only comes with a local answer.
    `MMBD_ASSERT_IMPL(a_data_local, clk, rst_n, m_tvalid && read_data != 8'd0,
        local_answer, "read data without local answer")

    // A blocked access never reaches an external target.
    `MMBD_ASSERT_IMPL(a_blocked_no_fwd, clk, rst_n,
        m_tvalid && target == mmbd_pkg::TGT_BLOCKED, !forward_write,
        "blocked access forwarded")

endmodule

`default_nettype wire
